@@ rtl/core/sdt_pkg.sv @@
package sdt_pkg;

	// Width of the request and result fields on the ports.
	localparam int DATA_W = 64;

	// Default operand width of the divider core.
	localparam int WIDTH_DEFAULT = 64;

	typedef struct packed {
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} sdt_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] quotient;
		logic [DATA_W-1:0] remainder;
	} sdt_res_t;

	// Control that travels down the pipeline next to the operands.
	typedef struct packed {
		logic valid;
		logic neg_q;
		logic neg_r;
	} sdt_ctl_t;

endpackage

@@ rtl/core/sdt_step.sv @@
module sdt_step #(
	parameter int WIDTH = sdt_pkg::WIDTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sdt_pkg::sdt_ctl_t prev_ctl,
	input  logic [WIDTH-1:0]  prev_rem,
	input  logic [WIDTH-1:0]  prev_nq,
	input  logic [WIDTH-1:0]  prev_den,
	output sdt_pkg::sdt_ctl_t ctl,
	output logic [WIDTH-1:0]  rem,
	output logic [WIDTH-1:0]  nq,
	output logic [WIDTH-1:0]  den
);

	sdt_pkg::sdt_ctl_t ctl_s1;
	logic [WIDTH-1:0]  rem_s1;
	logic [WIDTH-1:0]  nq_s1;
	logic [WIDTH-1:0]  den_s1;

	logic [WIDTH-1:0]  shifted;
	logic [WIDTH:0]    diff;
	logic              fits;

	// The partial remainder stays below a nonzero divisor and holds no more than
	// the bits shifted in so far, so its top bit is always clear and the shift
	// loses nothing. Dividend bits leave nq at the top, quotient bits enter below.
	assign shifted = {prev_rem[WIDTH-2:0], prev_nq[WIDTH-1]};
	assign diff    = {1'b0, shifted} - {1'b0, prev_den};
	assign fits    = ~diff[WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= prev_ctl;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1 <= fits ? diff[WIDTH-1:0] : shifted;
		nq_s1  <= {prev_nq[WIDTH-2:0], fits};
		den_s1 <= prev_den;
	end

	assign ctl = ctl_s1;
	assign rem = rem_s1;
	assign nq  = nq_s1;
	assign den = den_s1;

endmodule

@@ rtl/core/signed_divide_truncating.sv @@
// Pipelined signed divider, quotient truncated toward zero.
//
// A request (dividend, divisor) is taken at a rising edge where start is high
// and busy is low. busy never rises: a new request may enter on every cycle.
// Only the low WIDTH bits of each operand are used, read as two's complement.
// The result is shown on result for one cycle with done high; done and result
// are registered behind the last per-bit stage, from its valid bit and its
// sign-fixed quotient and remainder. Results leave in request order.
// Pipeline: one stage takes the operand magnitudes, WIDTH stages each resolve
// one quotient bit by restoring compare-subtract, and the last stage restores
// the signs and sign-extends to 64 bits. The per-bit stages set the latency.
// The remainder has the sign of the dividend. The most negative value over
// minus one gives the most negative value with remainder 0; a zero divisor
// gives quotient -1 (non-negative dividend) or +1 (negative dividend) with the
// dividend as remainder.
// Reset clears all valid bits; requests in flight are dropped.
// The receiver cannot hold results off, so the pipeline never stalls.
module signed_divide_truncating #(
	parameter int WIDTH = sdt_pkg::WIDTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sdt_pkg::sdt_req_t request,
	output logic              done,
	output sdt_pkg::sdt_res_t result
);

	sdt_pkg::sdt_ctl_t ctl_p [0:WIDTH];
	logic [WIDTH-1:0]  rem_p [0:WIDTH];
	logic [WIDTH-1:0]  nq_p  [0:WIDTH];
	logic [WIDTH-1:0]  den_p [0:WIDTH];

	logic [WIDTH-1:0]  a;
	logic [WIDTH-1:0]  b;
	logic              a_neg;
	logic              b_neg;

	sdt_pkg::sdt_ctl_t ctl_s1;
	logic [WIDTH-1:0]  nq_s1;
	logic [WIDTH-1:0]  den_s1;

	logic signed [WIDTH-1:0] q_fix;
	logic signed [WIDTH-1:0] r_fix;

	logic              done_q;
	sdt_pkg::sdt_res_t result_q;

	assign busy = 1'b0;

	assign a     = request.dividend[WIDTH-1:0];
	assign b     = request.divisor[WIDTH-1:0];
	assign a_neg = a[WIDTH-1];
	assign b_neg = b[WIDTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= start & ~busy;
			ctl_s1.neg_q <= a_neg ^ b_neg;
			ctl_s1.neg_r <= a_neg;
		end
	end

	always_ff @(posedge clk) begin
		nq_s1  <= a_neg ? (WIDTH'(0) - a) : a;
		den_s1 <= b_neg ? (WIDTH'(0) - b) : b;
	end

	assign ctl_p[0] = ctl_s1;
	assign rem_p[0] = '0;
	assign nq_p[0]  = nq_s1;
	assign den_p[0] = den_s1;

	for (genvar i = 0; i < WIDTH; i++) begin : g_step
		sdt_step #(
			.WIDTH (WIDTH)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev_ctl (ctl_p[i]),
			.prev_rem (rem_p[i]),
			.prev_nq  (nq_p[i]),
			.prev_den (den_p[i]),
			.ctl      (ctl_p[i+1]),
			.rem      (rem_p[i+1]),
			.nq       (nq_p[i+1]),
			.den      (den_p[i+1])
		);
	end

	// After the last step nq holds the unsigned quotient.
	assign q_fix = ctl_p[WIDTH].neg_q ? (WIDTH'(0) - nq_p[WIDTH]) : nq_p[WIDTH];
	assign r_fix = ctl_p[WIDTH].neg_r ? (WIDTH'(0) - rem_p[WIDTH]) : rem_p[WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_p[WIDTH].valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.quotient  <= sdt_pkg::DATA_W'(q_fix);
		result_q.remainder <= sdt_pkg::DATA_W'(r_fix);
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(WIDTH+2) done)
		else $error("accepted request produced no result after WIDTH+2 cycles");

	a_done_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, WIDTH+2))
		else $error("result strobe without a matching request");

endmodule
